// ----- src/frar_pkg.sv -----
package frar_pkg;

   // Operands are taken as the low OPW bits of each input field.
   localparam int OPW   = 16;
   localparam int PW    = 2 * OPW;
   localparam int NW    = PW + 1;
   localparam int MW    = PW;
   localparam int KW    = $clog2(MW + 1);
   localparam int NUM_W = 33;
   localparam int DEN_W = 31;
   localparam int XW    = ((MW > NUM_W) ? MW : NUM_W) + 1;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MUL_P,
      S_MUL_Q,
      S_MUL_D,
      S_SUM,
      S_MAG,
      S_GCD,
      S_GCD_END,
      S_DIV_INIT,
      S_DIV,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_MUL_P,
      DP_MUL_Q,
      DP_MUL_D,
      DP_SUM,
      DP_MAG,
      DP_GCD_STEP,
      DP_GCD_END,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_OUT
   } dp_cmd_type;

   typedef struct packed {
      logic err;
      logic gcd_done;
      logic div_done;
   } dp_sts_type;

endpackage

// ----- src/fraction_arith_reduce.sv -----
// Exact add, subtract, multiply or divide of two signed 16-bit fractions, reduced to lowest
// terms with a positive denominator. One request is worked at a time. After the accepting
// edge come the check, the three products on one shared multiplier, the sum and the
// magnitude step. The binary GCD loop then runs at one step per cycle, with no steps for a
// zero numerator, until one of its two working values on the 32-bit magnitudes reaches
// zero. The GCD is then formed and the divider set up. Two restoring lanes then divide
// numerator and denominator by the GCD, and a final step writes the result register.
// A zero denominator or a division by a zero fraction skips the arithmetic: its check
// goes straight to the finish step, which writes an error status and zero fields.
// The next request is taken as soon as the result is in the output register, even while
// that beat is stalled. A request that finishes while the previous beat is still stalled
// waits in its last step until that beat is taken.
module fraction_arith_reduce
   import frar_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic signed [15:0]      req_num_a,
   input  logic signed [15:0]      req_den_a,
   input  logic signed [15:0]      req_num_b,
   input  logic signed [15:0]      req_den_b,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [NUM_W-1:0] rsp_res_num,
   output logic [DEN_W-1:0]        rsp_res_den,
   output logic                    rsp_whole,
   output logic [1:0]              rsp_status
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   frar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_sts    (dp_sts)
   );

   frar_datapath u_datapath (
      .clock       (clock),
      .dp_cmd      (dp_cmd),
      .dp_sts      (dp_sts),
      .req_command (req_command),
      .req_num_a   (req_num_a),
      .req_den_a   (req_den_a),
      .req_num_b   (req_num_b),
      .req_den_b   (req_den_b),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_whole   (rsp_whole),
      .rsp_status  (rsp_status)
   );

endmodule

// ----- src/frar_datapath.sv -----
module frar_datapath
   import frar_pkg::*;
(
   input  logic                    clock,
   input  dp_cmd_type              dp_cmd,
   output dp_sts_type              dp_sts,
   input  logic [1:0]              req_command,
   input  logic signed [15:0]      req_num_a,
   input  logic signed [15:0]      req_den_a,
   input  logic signed [15:0]      req_num_b,
   input  logic signed [15:0]      req_den_b,
   output logic signed [NUM_W-1:0] rsp_res_num,
   output logic [DEN_W-1:0]        rsp_res_den,
   output logic                    rsp_whole,
   output logic [1:0]              rsp_status
);

   op_type                 cmd_ff;
   logic signed [OPW-1:0]  na_ff, da_ff, nb_ff, db_ff;
   logic signed [PW-1:0]   p_ff, q_ff, d_ff;
   logic signed [NW-1:0]   n_ff;
   logic [MW-1:0]          mn_ff, md_ff;
   logic                   neg_ff;
   logic [MW-1:0]          ga_ff, gb_ff, g_ff;
   logic [KW-1:0]          gk_ff;
   logic [MW-1:0]          qn_ff, qd_ff, rn_ff, rd_ff;
   logic [KW-1:0]          cnt_ff;
   logic signed [NUM_W-1:0] res_num_ff;
   logic [DEN_W-1:0]       res_den_ff;
   logic                   whole_ff;
   status_type             status_ff;

   logic signed [OPW-1:0]  mul_x, mul_y;
   logic signed [PW-1:0]   prod;
   logic signed [NW-1:0]   n_in;
   logic [NW-1:0]          n_abs;
   logic [PW-1:0]          d_abs;
   logic [MW-1:0]          ga_in, gb_in;
   logic [KW-1:0]          gk_in;
   logic [MW:0]            trial_n, trial_d, sub_n, sub_d;
   logic                   ge_n, ge_d;
   logic [MW-1:0]          rn_in, rd_in;
   status_type             st;
   logic [XW-1:0]          qn_x, qd_x, num_x;
   logic                   neg_eff;

   // One shared multiplier; the controller picks the operand pair.
   always_comb begin
      case (dp_cmd)
         DP_MUL_P: begin
            mul_x = na_ff;
            mul_y = (cmd_ff == CMD_MUL) ? nb_ff : db_ff;
         end
         DP_MUL_Q: begin
            mul_x = nb_ff;
            mul_y = da_ff;
         end
         DP_MUL_D: begin
            mul_x = da_ff;
            mul_y = (cmd_ff == CMD_DIV) ? nb_ff : db_ff;
         end
         default: begin
            mul_x = na_ff;
            mul_y = db_ff;
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   always_comb begin
      case (cmd_ff)
         CMD_ADD: n_in = NW'(p_ff) + NW'(q_ff);
         CMD_SUB: n_in = NW'(p_ff) - NW'(q_ff);
         default: n_in = NW'(p_ff);
      endcase
   end

   assign n_abs = n_ff[NW-1] ? (~n_ff + 1'b1) : n_ff;
   assign d_abs = d_ff[PW-1] ? (~d_ff + 1'b1) : d_ff;

   // Binary GCD; an odd-odd step subtracts and halves the even difference at once.
   always_comb begin
      ga_in = ga_ff;
      gb_in = gb_ff;
      gk_in = gk_ff;
      if (!ga_ff[0] && !gb_ff[0]) begin
         ga_in = ga_ff >> 1;
         gb_in = gb_ff >> 1;
         gk_in = gk_ff + 1'b1;
      end else if (!ga_ff[0]) begin
         ga_in = ga_ff >> 1;
      end else if (!gb_ff[0]) begin
         gb_in = gb_ff >> 1;
      end else if (ga_ff >= gb_ff) begin
         ga_in = (ga_ff - gb_ff) >> 1;
      end else begin
         gb_in = (gb_ff - ga_ff) >> 1;
      end
   end

   // Two restoring divider lanes share the divisor g.
   assign trial_n = {rn_ff, qn_ff[MW-1]};
   assign trial_d = {rd_ff, qd_ff[MW-1]};
   assign sub_n   = trial_n - {1'b0, g_ff};
   assign sub_d   = trial_d - {1'b0, g_ff};
   assign ge_n    = trial_n >= {1'b0, g_ff};
   assign ge_d    = trial_d >= {1'b0, g_ff};
   assign rn_in   = ge_n ? sub_n[MW-1:0] : trial_n[MW-1:0];
   assign rd_in   = ge_d ? sub_d[MW-1:0] : trial_d[MW-1:0];

   always_comb begin
      if (da_ff == '0 || db_ff == '0) begin
         st = ST_ZERO_DEN;
      end else if (cmd_ff == CMD_DIV && nb_ff == '0) begin
         st = ST_DIV_ZERO;
      end else begin
         st = ST_OK;
      end
   end

   assign neg_eff = neg_ff && (qn_ff != '0);
   assign qn_x    = XW'(qn_ff);
   assign qd_x    = XW'(qd_ff);
   assign num_x   = neg_eff ? (~qn_x + 1'b1) : qn_x;

   always_ff @(posedge clock) begin
      case (dp_cmd)
         DP_LOAD: begin
            cmd_ff <= op_type'(req_command);
            na_ff  <= req_num_a[OPW-1:0];
            da_ff  <= req_den_a[OPW-1:0];
            nb_ff  <= req_num_b[OPW-1:0];
            db_ff  <= req_den_b[OPW-1:0];
         end
         DP_MUL_P: p_ff <= prod;
         DP_MUL_Q: q_ff <= prod;
         DP_MUL_D: d_ff <= prod;
         DP_SUM:   n_ff <= n_in;
         DP_MAG: begin
            mn_ff  <= n_abs[MW-1:0];
            md_ff  <= d_abs;
            ga_ff  <= n_abs[MW-1:0];
            gb_ff  <= d_abs;
            gk_ff  <= '0;
            neg_ff <= n_ff[NW-1] ^ d_ff[PW-1];
         end
         DP_GCD_STEP: begin
            ga_ff <= ga_in;
            gb_ff <= gb_in;
            gk_ff <= gk_in;
         end
         // One of the two is zero here, so the OR, shifted back by the common twos, is the GCD.
         DP_GCD_END: g_ff <= (ga_ff | gb_ff) << gk_ff;
         DP_DIV_INIT: begin
            qn_ff  <= mn_ff;
            qd_ff  <= md_ff;
            rn_ff  <= '0;
            rd_ff  <= '0;
            cnt_ff <= '0;
         end
         DP_DIV_STEP: begin
            qn_ff  <= {qn_ff[MW-2:0], ge_n};
            qd_ff  <= {qd_ff[MW-2:0], ge_d};
            rn_ff  <= rn_in;
            rd_ff  <= rd_in;
            cnt_ff <= cnt_ff + 1'b1;
         end
         DP_OUT: begin
            status_ff <= st;
            if (st != ST_OK) begin
               res_num_ff <= '0;
               res_den_ff <= '0;
               whole_ff   <= 1'b0;
            end else begin
               res_num_ff <= num_x[NUM_W-1:0];
               res_den_ff <= qd_x[DEN_W-1:0];
               whole_ff   <= (qd_ff == MW'(1));
            end
         end
         default: begin
         end
      endcase
   end

   assign dp_sts.err      = (st != ST_OK);
   assign dp_sts.gcd_done = (ga_ff == '0) || (gb_ff == '0);
   assign dp_sts.div_done = (cnt_ff == KW'(MW));

   assign rsp_res_num = res_num_ff;
   assign rsp_res_den = res_den_ff;
   assign rsp_whole   = whole_ff;
   assign rsp_status  = status_ff;

endmodule

// ----- src/frar_ctrl.sv -----
module frar_ctrl
   import frar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type dp_cmd,
   input  dp_sts_type dp_sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dp_cmd       = DP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd   = DP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK:    state_in = dp_sts.err ? S_FINISH : S_MUL_P;
         S_MUL_P: begin
            dp_cmd   = DP_MUL_P;
            state_in = S_MUL_Q;
         end
         S_MUL_Q: begin
            dp_cmd   = DP_MUL_Q;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            dp_cmd   = DP_MUL_D;
            state_in = S_SUM;
         end
         S_SUM: begin
            dp_cmd   = DP_SUM;
            state_in = S_MAG;
         end
         S_MAG: begin
            dp_cmd   = DP_MAG;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (dp_sts.gcd_done) begin
               state_in = S_GCD_END;
            end else begin
               dp_cmd = DP_GCD_STEP;
            end
         end
         S_GCD_END: begin
            dp_cmd   = DP_GCD_END;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            dp_cmd   = DP_DIV_INIT;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (dp_sts.div_done) begin
               state_in = S_FINISH;
            end else begin
               dp_cmd = DP_DIV_STEP;
            end
         end
         S_FINISH: begin
            // The result register is free once its last beat has been taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd       = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_CHECK))
      else $error("accepted beat did not start the sequence");

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside the finish state");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && dp_sts.div_done) |=> (state_ff == S_FINISH))
      else $error("divider done without moving to finish");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd == DP_OUT) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register written while a stalled beat is pending");

endmodule

// ----- bench/tb.sv -----
module tb;
   import frar_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLD_START     = 150;
   localparam int HOLD_LENGTH    = 800;

   typedef struct {
      op_type             cmd;
      logic signed [15:0] num_a;
      logic signed [15:0] den_a;
      logic signed [15:0] num_b;
      logic signed [15:0] den_b;
      int                 gap;
   } frac_request_type;

   typedef struct {
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
      logic                    whole;
      status_type              status;
   } fraction_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_command = 2'd0;
   logic signed [15:0]      req_num_a = '0;
   logic signed [15:0]      req_den_a = '0;
   logic signed [15:0]      req_num_b = '0;
   logic signed [15:0]      req_den_b = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [NUM_W-1:0] rsp_res_num;
   logic [DEN_W-1:0]        rsp_res_den;
   logic                    rsp_whole;
   logic [1:0]              rsp_status;

   frac_request_type    pending_reqs[$];
   fraction_result_type expected_results[$];
   frac_request_type    next_req;
   bit                  have_next = 1'b0;
   int                  idle_left = 0;
   int                  stall_left = 0;
   int                  mismatch_count = 0;
   int                  results_seen = 0;
   int                  idle_cycles = 0;
   int                  hold_cycles = 0;
   bit                  hold_on = 1'b0;
   bit                  hold_done = 1'b0;

   fraction_arith_reduce u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_num_a   (req_num_a),
      .req_den_a   (req_den_a),
      .req_num_b   (req_num_b),
      .req_den_b   (req_den_b),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_whole   (rsp_whole),
      .rsp_status  (rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Exact result of one request: cross-multiply, then reduce by the GCD of the magnitudes.
   function automatic fraction_result_type reduce_fraction(op_type cmd,
                                                           logic signed [15:0] a_n,
                                                           logic signed [15:0] a_d,
                                                           logic signed [15:0] b_n,
                                                           logic signed [15:0] b_d);
      fraction_result_type r;
      longint na, da, nb, db, n, d, signed_num;
      longint unsigned mn, md, x, y, t;
      bit neg;
      na = a_n;
      da = a_d;
      nb = b_n;
      db = b_d;
      r.num = '0;
      r.den = '0;
      r.whole = 1'b0;
      r.status = ST_OK;
      // A zero denominator wins over a division by a zero fraction.
      if (da == 0 || db == 0) begin
         r.status = ST_ZERO_DEN;
         return r;
      end
      if (cmd == CMD_DIV && nb == 0) begin
         r.status = ST_DIV_ZERO;
         return r;
      end
      case (cmd)
         CMD_ADD: begin
            n = na * db + nb * da;
            d = da * db;
         end
         CMD_SUB: begin
            n = na * db - nb * da;
            d = da * db;
         end
         CMD_MUL: begin
            n = na * nb;
            d = da * db;
         end
         default: begin
            n = na * db;
            d = da * nb;
         end
      endcase
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      x = mn;
      y = md;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      mn = mn / x;
      md = md / x;
      neg = ((n < 0) != (d < 0)) && (mn != 0);
      signed_num = neg ? -longint'(mn) : longint'(mn);
      r.num = signed_num[NUM_W-1:0];
      r.den = md[DEN_W-1:0];
      r.whole = (md == 1);
      return r;
   endfunction

   // Mostly no idle time, sometimes a short gap, rarely a long stretch.
   function automatic int idle_length();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60)
         return 0;
      else if (sel < 85)
         return $urandom_range(1, 4);
      else if (sel < 96)
         return $urandom_range(5, 40);
      else
         return $urandom_range(41, 200);
   endfunction

   function automatic logic signed [15:0] pick_operand();
      int sel;
      int v;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         return 16'($urandom);
      end else if (sel < 80) begin
         v = $urandom_range(0, 24);
         return 16'(v - 12);
      end else if (sel < 90) begin
         case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd1;
            3: return 16'sd1;
            default: return 16'sh8001;
         endcase
      end else begin
         v = 1 << $urandom_range(0, 14);
         return ($urandom_range(0, 1) == 1) ? 16'(-v) : 16'(v);
      end
   endfunction

   task automatic queue_request(op_type cmd, logic signed [15:0] na, logic signed [15:0] da,
                                logic signed [15:0] nb, logic signed [15:0] db, int gap);
      frac_request_type req;
      req.cmd = cmd;
      req.num_a = na;
      req.den_a = da;
      req.num_b = nb;
      req.den_b = db;
      req.gap = gap;
      pending_reqs.push_back(req);
   endtask

   initial begin
      bit burst;
      op_type cmd;

      queue_request(CMD_ADD, 1, 2, 1, 3, 0);
      queue_request(CMD_SUB, 1, 2, 1, 3, 0);
      queue_request(CMD_MUL, 2, 3, 3, 4, 0);
      queue_request(CMD_DIV, 1, 2, 1, 4, 0);
      queue_request(CMD_SUB, 1, 2, 1, 2, 0);
      queue_request(CMD_MUL, 0, 5, 7, -3, 0);
      queue_request(CMD_ADD, 1, -3, 1, -6, 0);
      queue_request(CMD_DIV, -3, 4, 3, -8, 0);
      queue_request(CMD_DIV, 1, 3, -2, 5, 0);
      queue_request(CMD_MUL, -32768, 1, -32768, 1, 0);
      queue_request(CMD_MUL, 1, -32768, 1, -32768, 0);
      queue_request(CMD_ADD, -32768, 32767, -32768, 32765, 0);
      queue_request(CMD_SUB, 32767, -32768, -32768, 32767, 0);
      queue_request(CMD_DIV, -32768, -32768, 32767, -32768, 0);
      queue_request(CMD_DIV, -32768, 1, 1, -32768, 0);
      queue_request(CMD_MUL, 32767, 32767, 32767, 32767, 0);
      queue_request(CMD_ADD, 7, -1, -7, 1, 0);
      queue_request(CMD_ADD, 5, 0, 1, 2, 0);
      queue_request(CMD_SUB, 1, 2, 3, 0, 0);
      queue_request(CMD_DIV, 1, 0, 0, 3, 0);
      queue_request(CMD_MUL, 0, 0, 0, 0, 0);
      queue_request(CMD_DIV, 4, 5, 0, 7, 0);

      // Random requests in blocks; some blocks run back to back with no gaps at all.
      burst = 1'b0;
      for (int i = 0; i < 1330; i++) begin
         if (i % 64 == 0)
            burst = ($urandom_range(0, 3) == 0);
         cmd = op_type'($urandom_range(0, 3));
         queue_request(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand(),
                       burst ? 0 : idle_length());
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_reqs.size() > 0 || have_next || req_valid || expected_results.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Request driver: a beat is taken when valid is high and stall is low at the edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(reduce_fraction(op_type'(req_command), req_num_a,
                                                       req_den_a, req_num_b, req_den_b));
         if (!req_valid || !req_stall) begin
            if (!have_next && pending_reqs.size() > 0) begin
               next_req = pending_reqs.pop_front();
               have_next = 1'b1;
               idle_left = next_req.gap;
            end
            if (have_next && idle_left == 0) begin
               req_command <= next_req.cmd;
               req_num_a   <= next_req.num_a;
               req_den_a   <= next_req.den_a;
               req_num_b   <= next_req.num_b;
               req_den_b   <= next_req.den_b;
               req_valid   <= 1'b1;
               have_next = 1'b0;
            end else begin
               req_valid <= 1'b0;
               if (idle_left > 0)
                  idle_left--;
            end
         end
      end
   end

   // Result monitor and receiver stall.
   always @(posedge clock) begin
      fraction_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat, num %0d den %0d whole %0d status %0d",
                        $time, rsp_res_num, rsp_res_den, rsp_whole, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_res_num !== want.num) begin
                  $display("%0t: res_num mismatch, expected %0d, actual %0d",
                           $time, want.num, rsp_res_num);
                  mismatch_count++;
               end
               if (rsp_res_den !== want.den) begin
                  $display("%0t: res_den mismatch, expected %0d, actual %0d",
                           $time, want.den, rsp_res_den);
                  mismatch_count++;
               end
               if (rsp_whole !== want.whole) begin
                  $display("%0t: whole mismatch, expected %0d, actual %0d",
                           $time, want.whole, rsp_whole);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end

         // Every fourth window of results adds no new stalls, apart from the long hold.
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if ((results_seen / 128) % 4 == 1) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = idle_length();
            if (stall_left > 0) begin
               rsp_stall <= 1'b1;
               stall_left--;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // One long receiver hold-off so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_on <= 1'b0;
         hold_done <= 1'b0;
         hold_cycles <= 0;
      end else if (!hold_done && !hold_on && results_seen >= HOLD_START) begin
         hold_on <= 1'b1;
         hold_cycles <= 0;
      end else if (hold_on) begin
         if (hold_cycles == HOLD_LENGTH) begin
            hold_on <= 1'b0;
            hold_done <= 1'b1;
         end else begin
            hold_cycles <= hold_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/frar_pkg.sv
src/frar_datapath.sv
src/frar_ctrl.sv
src/fraction_arith_reduce.sv
bench/tb.sv
